### sv/nhe_pkg.sv
// Shared types and constants for the NAL header parser and EPB remover.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nhe_pkg;

    // Result item kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FORBIDDEN = 2'd1;
    localparam logic [1:0] ERR_UNSUPP    = 2'd2;
    localparam logic [1:0] ERR_SHORT     = 2'd3;

    // H.264 unit types this block does not handle
    localparam logic [4:0] UT_PREFIX_SVC = 5'd14;
    localparam logic [4:0] UT_SLICE_SVC  = 5'd20;
    localparam logic [4:0] UT_SLICE_3D   = 5'd21;

    // Emulation prevention byte
    localparam logic [7:0] EPB_BYTE = 8'h03;

    // Most result items one input item can cause
    localparam int RES_SLOTS = 3;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] payload_byte;
        logic [5:0] unit_type;
        logic [1:0] ref_idc;
        logic [5:0] layer_id;
        logic [2:0] temporal_id_plus1;
        logic [1:0] error_code;
        logic       last_of_unit;
    } t_result;

    // A payload result item
    function automatic t_result mk_payload(input logic [7:0] b, input logic last);
        t_result r;
        r = '0;
        r.item_kind    = KIND_PAYLOAD;
        r.payload_byte = b;
        r.last_of_unit = last;
        return r;
    endfunction

endpackage

### sv/nhe_parser.sv
// Header parse and emulation prevention removal for one item per cycle while i_accept is high.
// Holds the unit state and the codec register; depends on nhe_pkg.
`timescale 1ns / 1ps

module nhe_parser import nhe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_accept,
    input  logic [7:0] i_nal_byte,
    input  logic       i_end_of_unit,
    output t_result    o_res [RES_SLOTS],
    output logic [1:0] o_res_cnt
);

    logic       r_codec;
    logic [1:0] r_hdr_seen, n_hdr_seen;
    logic [7:0] r_first_hdr, n_first_hdr;
    logic [7:0] r_pend [2];
    logic [7:0] n_pend [2];
    logic [1:0] r_pend_cnt, n_pend_cnt;
    logic       r_drop, n_drop;

    logic [1:0] hlen;
    logic       forb;
    logic [5:0] ut;
    logic [1:0] ri;
    logic [5:0] li;
    logic [2:0] tid;
    logic [1:0] ec;
    logic [7:0] b;
    logic       last;

    assign b    = i_nal_byte;
    assign last = i_end_of_unit;
    assign hlen = r_codec ? 2'd2 : 2'd1;

    // Header field extraction for both codecs
    always_comb begin
        ri  = '0;
        li  = '0;
        tid = '0;
        ec  = ERR_NONE;
        if (!r_codec) begin
            forb = b[7];
            ri   = b[6:5];
            ut   = {1'b0, b[4:0]};
            if (forb) begin
                ec = ERR_FORBIDDEN;
            end else if (b[4:0] == UT_PREFIX_SVC || b[4:0] == UT_SLICE_SVC ||
                         b[4:0] == UT_SLICE_3D) begin
                ec = ERR_UNSUPP;
            end
        end else begin
            forb = r_first_hdr[7];
            ut   = r_first_hdr[6:1];
            li   = {r_first_hdr[0], b[7:3]};
            tid  = b[2:0];
            if (forb) begin
                ec = ERR_FORBIDDEN;
            end
        end
    end

    // Next state and result items for the current item
    always_comb begin
        n_hdr_seen  = r_hdr_seen;
        n_first_hdr = r_first_hdr;
        n_pend      = r_pend;
        n_pend_cnt  = r_pend_cnt;
        n_drop      = r_drop;
        o_res[0]    = '0;
        o_res[1]    = '0;
        o_res[2]    = '0;
        o_res_cnt   = 2'd0;

        if (r_drop) begin
            // discard the rest of a bad unit
            if (last) begin
                n_drop = 1'b0;
                n_hdr_seen = 2'd0;
                n_pend_cnt = 2'd0;
            end
        end else if (r_hdr_seen < hlen) begin
            if (r_codec && r_hdr_seen == 2'd0) begin
                // first of two header bytes
                n_first_hdr = b;
                n_hdr_seen  = 2'd1;
                if (last) begin
                    o_res[0].item_kind    = KIND_ERROR;
                    o_res[0].error_code   = ERR_SHORT;
                    o_res[0].last_of_unit = 1'b1;
                    o_res_cnt  = 2'd1;
                    n_hdr_seen = 2'd0;
                    n_pend_cnt = 2'd0;
                end
            end else begin
                o_res[0].item_kind         = (ec != ERR_NONE) ? KIND_ERROR : KIND_HEADER;
                o_res[0].unit_type         = ut;
                o_res[0].ref_idc           = ri;
                o_res[0].layer_id          = li;
                o_res[0].temporal_id_plus1 = tid;
                o_res[0].error_code        = ec;
                o_res[0].last_of_unit      = (ec != ERR_NONE) | last;
                o_res_cnt  = 2'd1;
                n_hdr_seen = hlen;
                if (last) begin
                    n_hdr_seen = 2'd0;
                    n_pend_cnt = 2'd0;
                end else if (ec != ERR_NONE) begin
                    n_drop = 1'b1;
                end
            end
        end else if (r_pend_cnt == 2'd2) begin
            if (r_pend[0] == 8'h00 && r_pend[1] == 8'h00 && b == EPB_BYTE) begin
                // 00 00 03: drop the 03 and restart the scan
                o_res[0]   = mk_payload(8'h00, 1'b0);
                o_res[1]   = mk_payload(8'h00, last);
                o_res_cnt  = 2'd2;
                n_pend_cnt = 2'd0;
                if (last) begin
                    n_hdr_seen = 2'd0;
                end
            end else begin
                o_res[0]  = mk_payload(r_pend[0], 1'b0);
                n_pend[0] = r_pend[1];
                n_pend[1] = b;
                o_res_cnt = 2'd1;
                if (last) begin
                    o_res[1]   = mk_payload(r_pend[1], 1'b0);
                    o_res[2]   = mk_payload(b, 1'b1);
                    o_res_cnt  = 2'd3;
                    n_hdr_seen = 2'd0;
                    n_pend_cnt = 2'd0;
                end
            end
        end else begin
            n_pend[r_pend_cnt[0]] = b;
            n_pend_cnt = r_pend_cnt + 2'd1;
            if (last) begin
                // flush the short tail unchanged
                if (r_pend_cnt == 2'd0) begin
                    o_res[0]  = mk_payload(b, 1'b1);
                    o_res_cnt = 2'd1;
                end else begin
                    o_res[0]  = mk_payload(r_pend[0], 1'b0);
                    o_res[1]  = mk_payload(b, 1'b1);
                    o_res_cnt = 2'd2;
                end
                n_hdr_seen = 2'd0;
                n_pend_cnt = 2'd0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec     <= 1'b0;
            r_hdr_seen  <= 2'd0;
            r_first_hdr <= 8'h00;
            r_pend_cnt  <= 2'd0;
            r_drop      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_codec <= i_cfg_data;
            end
            if (i_accept) begin
                r_hdr_seen  <= n_hdr_seen;
                r_first_hdr <= n_first_hdr;
                r_pend_cnt  <= n_pend_cnt;
                r_drop      <= n_drop;
            end
        end
    end

    // Pending bytes, valid only below the pending count
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

### sv/nhe_out_buf.sv
// Result register: holds up to three result items of one input item.
// Drains one item per cycle from slot 0 while i_ready is high; depends on nhe_pkg.
`timescale 1ns / 1ps

module nhe_out_buf import nhe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_result    i_res [RES_SLOTS],
    input  logic [1:0] i_res_cnt,
    input  logic       i_load,
    output logic       o_can_load,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);

    t_result    r_slot [RES_SLOTS];
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid & i_ready;
    // room for a new group once the last held item leaves
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign o_res      = r_slot[0];

    // Item count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Slots: load a new group or shift toward slot 0
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_res;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

### sv/nal_header_and_epb_removal_top.sv
// NAL header parser and emulation prevention byte remover, top level.
// The first result is registered and appears in the cycle after its input
// is taken. Throughput: one item per cycle while each causes at most one
// result and the output does not stall; an item with two or three results
// holds input until the single output port has drained all but the last.
// Synchronous active-low reset clears unit state, codec select to H.264.
`timescale 1ns / 1ps

module nal_header_and_epb_removal_top import nhe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_nal_byte,
    input  logic       i_end_of_unit,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_item_kind,
    output logic [7:0] o_payload_byte,
    output logic [5:0] o_unit_type,
    output logic [1:0] o_ref_idc,
    output logic [5:0] o_layer_id,
    output logic [2:0] o_temporal_id_plus1,
    output logic [1:0] o_error_code,
    output logic       o_last_of_unit
);

    t_result    res [RES_SLOTS];
    logic [1:0] res_cnt;
    logic       accept;
    t_result    out_res;

    assign accept = i_valid & o_ready;

    nhe_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_nal_byte    (i_nal_byte),
        .i_end_of_unit (i_end_of_unit),
        .o_res         (res),
        .o_res_cnt     (res_cnt)
    );

    nhe_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .i_res_cnt  (res_cnt),
        .i_load     (accept),
        .o_can_load (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    // Output fields
    assign o_item_kind         = out_res.item_kind;
    assign o_payload_byte      = out_res.payload_byte;
    assign o_unit_type         = out_res.unit_type;
    assign o_ref_idc           = out_res.ref_idc;
    assign o_layer_id          = out_res.layer_id;
    assign o_temporal_id_plus1 = out_res.temporal_id_plus1;
    assign o_error_code        = out_res.error_code;
    assign o_last_of_unit      = out_res.last_of_unit;

endmodule

### bench/nhe_rbsp_checker.sv
// Result checker for the NAL header parser and EPB remover: watches both
// channels and the codec register, predicts each result item, compares.
// Depends on nhe_pkg for the result struct, item kinds and error codes.
`timescale 1ns / 1ps

module nhe_rbsp_checker import nhe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_nal_byte,
    input  logic       i_end_of_unit,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_result    i_result,
    output int         o_mismatch_count,
    output int         o_expect_depth
);

    // Predicted unit state
    logic       codec_h265;
    logic [1:0] hdr_seen;
    logic [7:0] hdr_first;
    logic [7:0] held [0:1];
    logic [1:0] held_cnt;
    logic       dropping;

    t_result rbsp_expect_q [$];

    initial begin
        o_mismatch_count = 0;
        o_expect_depth   = 0;
    end

    task automatic log_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        o_mismatch_count++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            log_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    function automatic void close_unit();
        hdr_seen = 2'd0;
        held_cnt = 2'd0;
        dropping = 1'b0;
    endfunction

    function automatic void queue_payload(input logic [7:0] b, input logic last);
        t_result r;
        r              = '0;
        r.item_kind    = KIND_PAYLOAD;
        r.payload_byte = b;
        r.last_of_unit = last;
        rbsp_expect_q.push_back(r);
    endfunction

    // Expected result items for one accepted byte
    function automatic void rbsp_step(input logic [7:0] b, input logic eou);
        logic [1:0] hlen;
        logic [1:0] ec;
        t_result    r;
        int         i;
        hlen = codec_h265 ? 2'd2 : 2'd1;
        ec   = ERR_NONE;
        r    = '0;

        // rest of a bad unit is swallowed
        if (dropping) begin
            if (eou)
                close_unit();
            return;
        end

        if (hdr_seen < hlen) begin
            // first of two header bytes: hold it; a unit ending here is too short
            if (hlen == 2'd2 && hdr_seen == 2'd0) begin
                hdr_first = b;
                hdr_seen  = 2'd1;
                if (eou) begin
                    r.item_kind    = KIND_ERROR;
                    r.error_code   = ERR_SHORT;
                    r.last_of_unit = 1'b1;
                    rbsp_expect_q.push_back(r);
                    close_unit();
                end
                return;
            end
            if (hlen == 2'd1) begin
                r.ref_idc   = b[6:5];
                r.unit_type = {1'b0, b[4:0]};
                if (b[7])
                    ec = ERR_FORBIDDEN;
                else if (b[4:0] == UT_PREFIX_SVC || b[4:0] == UT_SLICE_SVC ||
                         b[4:0] == UT_SLICE_3D)
                    ec = ERR_UNSUPP;
            end else begin
                r.unit_type         = hdr_first[6:1];
                r.layer_id          = {hdr_first[0], b[7:3]};
                r.temporal_id_plus1 = b[2:0];
                if (hdr_first[7])
                    ec = ERR_FORBIDDEN;
            end
            hdr_seen = hlen;
            if (ec != ERR_NONE) begin
                r.item_kind    = KIND_ERROR;
                r.error_code   = ec;
                r.last_of_unit = 1'b1;
                rbsp_expect_q.push_back(r);
                if (eou)
                    close_unit();
                else
                    dropping = 1'b1;
                return;
            end
            r.item_kind    = KIND_HEADER;
            r.last_of_unit = eou;
            rbsp_expect_q.push_back(r);
            if (eou)
                close_unit();
            return;
        end

        // payload: two held bytes plus this one form the triple window
        if (held_cnt >= 2'd2) begin
            if (held[0] == 8'h00 && held[1] == 8'h00 && b == EPB_BYTE) begin
                queue_payload(8'h00, 1'b0);
                queue_payload(8'h00, eou);
                held_cnt = 2'd0;
                if (eou)
                    close_unit();
                return;
            end
            queue_payload(held[0], 1'b0);
            held[0] = held[1];
            held[1] = b;
        end else begin
            held[held_cnt[0]] = b;
            held_cnt++;
        end

        // unit tail flushes whatever is held
        if (eou) begin
            for (i = 0; i < held_cnt; i++)
                queue_payload(held[i], (i + 1 == held_cnt));
            close_unit();
        end
    endfunction

    // Outputs are matched before new expectations are added
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            codec_h265 = 1'b0;
            hdr_first  = 8'h00;
            close_unit();
            rbsp_expect_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rbsp_expect_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected result item, kind %0d",
                                           i_result.item_kind));
                end else begin
                    want = rbsp_expect_q.pop_front();
                    check_field("item_kind", want.item_kind, i_result.item_kind);
                    check_field("payload_byte", want.payload_byte,
                                i_result.payload_byte);
                    check_field("unit_type", want.unit_type, i_result.unit_type);
                    check_field("ref_idc", want.ref_idc, i_result.ref_idc);
                    check_field("layer_id", want.layer_id, i_result.layer_id);
                    check_field("temporal_id_plus1", want.temporal_id_plus1,
                                i_result.temporal_id_plus1);
                    check_field("error_code", want.error_code, i_result.error_code);
                    check_field("last_of_unit", want.last_of_unit,
                                i_result.last_of_unit);
                end
            end
            // the byte taken at this edge still sees the old codec
            if (i_in_valid && i_in_ready)
                rbsp_step(i_nal_byte, i_end_of_unit);
            if (i_cfg_we)
                codec_h265 = i_cfg_data;
        end
        o_expect_depth <= rbsp_expect_q.size();
    end

endmodule

### bench/tb_nal_header_and_epb_removal_top.sv
// Testbench top for the NAL header parser and EPB remover: clock, reset,
// directed and random NAL units, output stalls, watchdog and verdict.
// Depends on nhe_pkg, nal_header_and_epb_removal_top and nhe_rbsp_checker.
`timescale 1ns / 1ps

module tb_nal_header_and_epb_removal_top;
    import nhe_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 108;
    localparam int PHASES       = 6;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_nal_byte = 8'h00;
    logic       i_end_of_unit = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b1;
    logic [1:0] o_item_kind;
    logic [7:0] o_payload_byte;
    logic [5:0] o_unit_type;
    logic [1:0] o_ref_idc;
    logic [5:0] o_layer_id;
    logic [2:0] o_temporal_id_plus1;
    logic [1:0] o_error_code;
    logic       o_last_of_unit;

    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;
    int   stall_left = 0;
    int   bytes_sent = 0;
    logic idle_on = 1'b1;
    logic codec_now = 1'b0;

    always #2 i_clk = ~i_clk;

    nal_header_and_epb_removal_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_nal_byte          (i_nal_byte),
        .i_end_of_unit       (i_end_of_unit),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_item_kind         (o_item_kind),
        .o_payload_byte      (o_payload_byte),
        .o_unit_type         (o_unit_type),
        .o_ref_idc           (o_ref_idc),
        .o_layer_id          (o_layer_id),
        .o_temporal_id_plus1 (o_temporal_id_plus1),
        .o_error_code        (o_error_code),
        .o_last_of_unit      (o_last_of_unit)
    );

    nhe_rbsp_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_nal_byte       (i_nal_byte),
        .i_end_of_unit    (i_end_of_unit),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_result         ({o_item_kind, o_payload_byte, o_unit_type, o_ref_idc,
                            o_layer_id, o_temporal_id_plus1, o_error_code,
                            o_last_of_unit}),
        .o_mismatch_count (mismatches),
        .o_expect_depth   (outstanding)
    );

    // Output stalls in random bursts, only while idle_on is set
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL nal_header_and_epb_removal_top");
            $finish;
        end
    end

    // One byte of a unit; returns at the edge that accepts it, or after the idle gap that may follow
    task automatic send_byte(input logic [7:0] b, input logic eou);
        int gap;
        i_valid       <= 1'b1;
        i_nal_byte    <= b;
        i_end_of_unit <= eou;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait until every expected item has come out, then let the block settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_codec(input logic h265);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= h265;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        codec_now = h265;
    endtask

    // Mostly well-formed units; some bad headers and short units
    task automatic send_random_unit();
        logic [7:0] hb0;
        logic [7:0] hb1;
        logic [7:0] pb;
        int         flavor;
        int         plen;
        int         k;
        flavor = $urandom_range(0, 9);
        plen   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
        hb0    = 8'($urandom);
        hb1    = 8'($urandom);
        if (flavor != 0)
            hb0[7] = 1'b0;
        if (!codec_now) begin
            if (flavor == 1) begin
                case ($urandom_range(0, 2))
                    0:       hb0[4:0] = UT_PREFIX_SVC;
                    1:       hb0[4:0] = UT_SLICE_SVC;
                    default: hb0[4:0] = UT_SLICE_3D;
                endcase
            end else if (flavor > 1 && (hb0[4:0] == UT_PREFIX_SVC ||
                         hb0[4:0] == UT_SLICE_SVC || hb0[4:0] == UT_SLICE_3D)) begin
                hb0[4:0] = 5'd1;
            end
            send_byte(hb0, plen == 0);
        end else begin
            if (flavor == 1) begin
                send_byte(hb0, 1'b1);
                return;
            end
            send_byte(hb0, 1'b0);
            send_byte(hb1, plen == 0);
        end
        // zeros and 03 are frequent so triples and near-triples show up
        for (k = 0; k < plen; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pb = 8'h00;
                4, 5:       pb = EPB_BYTE;
                default:    pb = 8'($urandom);
            endcase
            send_byte(pb, k == plen - 1);
        end
    endtask

    initial begin : stimulus
        int phase;
        int phase_start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // H.264 headers: plain, forbidden bit, the three unsupported types
        write_codec(1'b0);
        send_byte(8'h65, 1'b1);
        send_byte(8'hE5, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'h0E, 1'b1);
        send_byte(8'h74, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h35, 1'b1);
        // triple removal, then a three-item flush on the final byte
        send_byte(8'h67, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(EPB_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);

        // H.265: header only, forbidden bit, too short, triple at the end
        write_codec(1'b1);
        send_byte(8'h40, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(EPB_BYTE, 1'b1);
        send_byte(8'h7E, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(EPB_BYTE, 1'b1);

        // codec switched inside a unit, both directions
        send_byte(8'h26, 1'b0);
        write_codec(1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h41, 1'b0);
        write_codec(1'b1);
        send_byte(8'h01, 1'b1);

        // random units; last phase runs with no idling on either side
        for (phase = 0; phase < PHASES; phase++) begin
            write_codec(phase == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
            idle_on     = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / PHASES)
                send_random_unit();
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS nal_header_and_epb_removal_top");
        else
            $display("FAIL nal_header_and_epb_removal_top");
        $finish;
    end

endmodule
